// ----- rtl/core/glzw_pkg.sv -----
// ----------------------------------------------------------------------------
// glzw_pkg: shared definitions for the GIF LZW decoder
// Command and status codes, default sizes and the control/status records
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package glzw_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DICT_ENTRIES_DEF  = 4096;
  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int STACK_DEPTH_DEF   = 4096;

  // Reset value of the minimum code size register.
  localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

  // Request commands.
  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_PULL    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_BYTE     = 3'd0;
  localparam logic [2:0] ST_TAKEN    = 3'd1;
  localparam logic [2:0] ST_REFUSED  = 3'd2;
  localparam logic [2:0] ST_NEED     = 3'd3;
  localparam logic [2:0] ST_END_CODE = 3'd4;
  localparam logic [2:0] ST_END_DATA = 3'd5;
  localparam logic [2:0] ST_RESTART  = 3'd6;

  // Source of a result written to the output register.
  typedef enum logic [1:0] {
    SEL_SIMPLE,
    SEL_NOCODE,
    SEL_END,
    SEL_PIXEL
  } emit_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_in;
    logic      do_simple;
    logic      clr_err;
    logic      take_code;
    logic      dict_clear;
    logic      fail;
    logic      push_lit;
    logic      start_walk;
    logic      start_kwk;
    logic      walk_read;
    logic      walk_push;
    logic      walk_term;
    logic      pop_read;
    logic      emit;
    emit_sel_t emit_sel;
  } glzw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pull;
    logic stack_empty;
    logic stack_full;
    logic out_free;
    logic no_code;
    logic code_clear;
    logic code_end;
    logic prev_clr;
    logic code_lit;
    logic code_normal;
    logic code_kwk;
    logic walk_more;
  } glzw_stat_t;

endpackage

// ----- rtl/core/glzw_ram.sv -----
// ----------------------------------------------------------------------------
// glzw_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/glzw_ctrl.sv -----
// ----------------------------------------------------------------------------
// glzw_ctrl: decoder controller
// Sequences pushes, restarts, code extraction, dictionary chain walks and
// stack pops, and decides when a result is written out.
// ----------------------------------------------------------------------------
module glzw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  glzw_pkg::glzw_stat_t stat,
  output glzw_pkg::glzw_cmd_t  cmd
);
  import glzw_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DISPATCH  = 7'b0000010,
    S_EXTRACT   = 7'b0000100,
    S_WALK_RD   = 7'b0001000,
    S_WALK_DATA = 7'b0010000,
    S_POP_RD    = 7'b0100000,
    S_POP_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_sel = SEL_SIMPLE;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_pull) begin
          cmd.clr_err = 1'b1;
          state_next  = stat.stack_empty ? S_EXTRACT : S_POP_RD;
        end else if (stat.out_free) begin
          cmd.do_simple = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_SIMPLE;
          state_next    = S_IDLE;
        end
      end
      S_EXTRACT: begin
        if (stat.no_code) begin
          if (stat.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = SEL_NOCODE;
            state_next   = S_IDLE;
          end
        end else if (stat.code_clear) begin
          cmd.take_code  = 1'b1;
          cmd.dict_clear = 1'b1;
        end else if (stat.code_end) begin
          if (stat.out_free) begin
            cmd.take_code = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_sel  = SEL_END;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.take_code = 1'b1;
          if (stat.prev_clr) begin
            // First code after a clear must be a literal.
            if (stat.code_lit) begin
              cmd.push_lit = 1'b1;
              state_next   = S_POP_RD;
            end else begin
              cmd.fail = 1'b1;
            end
          end else if (stat.code_normal) begin
            cmd.start_walk = 1'b1;
            state_next     = S_WALK_RD;
          end else if (stat.code_kwk) begin
            cmd.start_kwk = 1'b1;
            state_next    = S_WALK_RD;
          end else begin
            cmd.fail = 1'b1;
          end
        end
      end
      S_WALK_RD: begin
        if (stat.walk_more) begin
          cmd.walk_read = 1'b1;
          state_next    = S_WALK_DATA;
        end else if (stat.stack_full) begin
          cmd.fail   = 1'b1;
          state_next = S_EXTRACT;
        end else begin
          cmd.walk_term = 1'b1;
          state_next    = S_POP_RD;
        end
      end
      S_WALK_DATA: begin
        if (stat.stack_full) begin
          cmd.fail   = 1'b1;
          state_next = S_EXTRACT;
        end else begin
          cmd.walk_push = 1'b1;
          state_next    = S_WALK_RD;
        end
      end
      S_POP_RD: begin
        cmd.pop_read = 1'b1;
        state_next   = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_PIXEL;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/glzw_dp.sv -----
// ----------------------------------------------------------------------------
// glzw_dp: decoder datapath
// Bit accumulator, dictionary and stack memories, code classification and
// the output register.
// ----------------------------------------------------------------------------
module glzw_dp #(
  parameter int DICT_ENTRIES  = glzw_pkg::DICT_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
  parameter int STACK_DEPTH   = glzw_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_wdata,
  input  logic [7:0]           s_tdata,
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic [3:0]           m_tuser,
  input  glzw_pkg::glzw_cmd_t  cmd,
  output glzw_pkg::glzw_stat_t stat
);
  import glzw_pkg::*;

  localparam int DAW = $clog2(DICT_ENTRIES);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam logic [12:0]  DICT_N   = 13'(DICT_ENTRIES);
  localparam logic [SAW:0] STACK_N  = (SAW+1)'(STACK_DEPTH);
  localparam logic [3:0]   MAX_BITS = 4'(MAX_CODE_BITS);

  // Configuration and stream state.
  logic [3:0]   min_cfg;
  logic [3:0]   act_size;
  logic [SAW:0] sc;
  logic [31:0]  acc;
  logic [5:0]   bc;
  logic [3:0]   cw;
  logic [12:0]  nfc;
  logic [12:0]  prev;
  logic [7:0]   prev_first;
  logic [7:0]   rem;
  logic         discard;
  logic         ended;
  logic         err;
  logic         kwk;
  logic [12:0]  cur_code;
  logic [12:0]  walk_c;
  logic [1:0]   in_cmd;
  logic [7:0]   in_byte;

  // Derived codes and the current code at the bottom of the accumulator.
  logic [12:0] clr_code;
  logic [12:0] end_code;
  logic [31:0] code_mask;
  logic [31:0] acc_masked;
  logic [12:0] code;
  logic [3:0]  rs_size;
  logic [12:0] rs_clr;
  logic [2:0]  simple_st;
  logic [12:0] nfc_inc;
  logic [13:0] width_limit;
  logic [7:0]  term_k;
  logic        out_free;

  assign clr_code   = 13'd1 << act_size;
  assign end_code   = clr_code + 13'd1;
  assign code_mask  = (32'd1 << cw) - 32'd1;
  assign acc_masked = acc & code_mask;
  assign code       = acc_masked[12:0];
  assign rs_size    = (min_cfg < 4'd2) ? 4'd2 : ((min_cfg > 4'd12) ? 4'd12 : min_cfg);
  assign rs_clr     = 13'd1 << rs_size;
  assign nfc_inc    = nfc + 13'd1;
  assign width_limit = 14'd1 << cw;
  assign term_k     = kwk ? prev_first : walk_c[7:0];
  assign out_free   = !m_tvalid || m_tready;

  // Memories.
  logic             st_we;
  logic [SAW-1:0]   st_waddr;
  logic [7:0]       st_wdata;
  logic [SAW-1:0]   st_raddr;
  logic [7:0]       st_rdata;
  logic             dict_we;
  logic [DAW-1:0]   pre_rdata;
  logic [7:0]       suf_rdata;
  logic [SAW:0]     sc_dec;

  assign sc_dec   = sc - 1'b1;
  assign st_raddr = sc_dec[SAW-1:0];
  assign st_waddr = sc[SAW-1:0];
  assign st_we    = cmd.push_lit || cmd.start_kwk || cmd.walk_push || cmd.walk_term;
  assign dict_we  = cmd.walk_term && (nfc < DICT_N);

  // Stack write data by source.
  always_comb begin
    if (cmd.push_lit) begin
      st_wdata = code[7:0];
    end else if (cmd.start_kwk) begin
      st_wdata = prev_first;
    end else if (cmd.walk_push) begin
      st_wdata = suf_rdata;
    end else begin
      st_wdata = walk_c[7:0];
    end
  end

  glzw_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (cmd.pop_read),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  glzw_ram #(.WIDTH(DAW), .DEPTH(DICT_ENTRIES)) u_prefix (
    .clk   (clk),
    .we    (dict_we),
    .waddr (nfc[DAW-1:0]),
    .wdata (prev[DAW-1:0]),
    .re    (cmd.walk_read),
    .raddr (walk_c[DAW-1:0]),
    .rdata (pre_rdata)
  );

  glzw_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_suffix (
    .clk   (clk),
    .we    (dict_we),
    .waddr (nfc[DAW-1:0]),
    .wdata (term_k),
    .re    (cmd.walk_read),
    .raddr (walk_c[DAW-1:0]),
    .rdata (suf_rdata)
  );

  // Status of a push, restart or unknown request.
  always_comb begin
    case (in_cmd)
      CMD_PUSH: begin
        if (ended) begin
          simple_st = ST_REFUSED;
        end else if (rem == 8'd0 || discard) begin
          simple_st = ST_TAKEN;
        end else if (bc > 6'd24) begin
          simple_st = ST_REFUSED;
        end else begin
          simple_st = ST_TAKEN;
        end
      end
      CMD_RESTART: simple_st = ST_RESTART;
      default:     simple_st = ST_REFUSED;
    endcase
  end

  // Status to the controller.
  always_comb begin
    stat.is_pull     = (in_cmd == CMD_PULL);
    stat.stack_empty = (sc == '0);
    stat.stack_full  = (sc >= STACK_N);
    stat.out_free    = out_free;
    stat.no_code     = (bc < {2'b00, cw});
    stat.code_clear  = (code == clr_code);
    stat.code_end    = (code == end_code);
    stat.prev_clr    = (prev == clr_code);
    stat.code_lit    = (code < clr_code);
    stat.code_normal = (code < clr_code) ||
                       ((code > end_code) && (code < nfc) && (code < DICT_N));
    stat.code_kwk    = (code == nfc) && (nfc < DICT_N);
    stat.walk_more   = (walk_c > end_code) && (walk_c < DICT_N);
  end

  // Request capture and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_cmd  <= s_tuser;
      in_byte <= s_tdata;
    end
    if (cmd.start_walk) begin
      cur_code <= code;
      walk_c   <= code;
      kwk      <= 1'b0;
    end
    if (cmd.start_kwk) begin
      cur_code <= code;
      walk_c   <= prev;
      kwk      <= 1'b1;
    end
    if (cmd.walk_push) begin
      walk_c <= 13'(pre_rdata);
    end
    if (cmd.push_lit) begin
      prev_first <= code[7:0];
    end
    if (cmd.walk_term) begin
      prev_first <= term_k;
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cfg  <= MIN_SIZE_RESET;
      act_size <= MIN_SIZE_RESET;
      sc       <= '0;
      acc      <= '0;
      bc       <= '0;
      cw       <= MIN_SIZE_RESET + 4'd1;
      nfc      <= (13'd1 << MIN_SIZE_RESET) + 13'd2;
      prev     <= 13'd1 << MIN_SIZE_RESET;
      rem      <= '0;
      discard  <= 1'b0;
      ended    <= 1'b0;
      err      <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_cfg <= cfg_wdata;
      end
      // Push, restart and unknown requests.
      if (cmd.do_simple) begin
        case (in_cmd)
          CMD_PUSH: begin
            if (!ended) begin
              if (rem == 8'd0) begin
                if (in_byte == 8'd0) begin
                  ended <= 1'b1;
                end else begin
                  rem <= in_byte;
                end
                discard <= 1'b0;
              end else if (discard) begin
                rem <= rem - 8'd1;
                if (rem == 8'd1) begin
                  discard <= 1'b0;
                end
              end else if (bc <= 6'd24) begin
                acc <= acc | ({24'd0, in_byte} << bc);
                bc  <= bc + 6'd8;
                rem <= rem - 8'd1;
              end
            end
          end
          CMD_RESTART: begin
            act_size <= rs_size;
            sc       <= '0;
            acc      <= '0;
            bc       <= '0;
            rem      <= '0;
            discard  <= 1'b0;
            ended    <= 1'b0;
            cw       <= rs_size + 4'd1;
            nfc      <= rs_clr + 13'd2;
            prev     <= rs_clr;
          end
          default: begin
          end
        endcase
      end
      if (cmd.clr_err) begin
        err <= 1'b0;
      end
      // Consume one code from the accumulator.
      if (cmd.take_code) begin
        acc <= acc >> cw;
        bc  <= bc - {2'b00, cw};
      end
      if (cmd.dict_clear) begin
        cw   <= act_size + 4'd1;
        nfc  <= clr_code + 13'd2;
        prev <= clr_code;
      end
      // Decode fault: drop the partial expansion and the rest of the block.
      if (cmd.fail) begin
        err <= 1'b1;
        sc  <= '0;
        if (rem != 8'd0) begin
          discard <= 1'b1;
        end
      end
      if (cmd.push_lit) begin
        sc   <= sc + 1'b1;
        prev <= code;
      end
      if (cmd.start_kwk || cmd.walk_push) begin
        sc <= sc + 1'b1;
      end
      // End of a chain walk: push the last byte and, if there is room, add the new dictionary entry.
      if (cmd.walk_term) begin
        sc   <= sc + 1'b1;
        prev <= cur_code;
        if (nfc < DICT_N) begin
          nfc <= nfc_inc;
          if ((cw < MAX_BITS) && ({1'b0, nfc_inc} == width_limit)) begin
            cw <= cw + 4'd1;
          end
        end
      end
      if (cmd.pop_read) begin
        sc <= sc_dec;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        SEL_SIMPLE: begin
          m_tdata <= 8'd0;
          m_tuser <= {1'b0, simple_st};
        end
        SEL_NOCODE: begin
          m_tdata <= 8'd0;
          m_tuser <= {err, (ended ? ST_END_DATA : ST_NEED)};
        end
        SEL_END: begin
          m_tdata <= 8'd0;
          m_tuser <= {err, ST_END_CODE};
        end
        default: begin
          m_tdata <= st_rdata;
          m_tuser <= {err, ST_BYTE};
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/gif_lzw_decoder.sv -----
// ----------------------------------------------------------------------------
// gif_lzw_decoder: GIF LZW image-data decoder with push/pull requests
// Push requests feed compressed bytes, pull requests return color indexes.
// ----------------------------------------------------------------------------
// Push, restart and unknown requests: result registered in dispatch once the output is free.
// Pull with bytes on the expansion stack: dispatch, stack read, then the byte once the output is free.
// Pull on a fresh code: a read state and a data state per string byte of the dictionary walk,
// since each step waits on the registered prefix/suffix memory read.
// One request at a time; the next is taken once the result is registered.
// Synchronous reset clears control state; memories are not cleared.
module gif_lzw_decoder #(
  parameter int DICT_ENTRIES  = glzw_pkg::DICT_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
  parameter int STACK_DEPTH   = glzw_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,   // min_code_size
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // data_byte
  input  logic [1:0] s_tuser,     // command
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // pixel_byte
  output logic [3:0] m_tuser      // status[2:0], decode_error[3]
);
  import glzw_pkg::*;

  glzw_cmd_t  cmd;
  glzw_stat_t stat;

  glzw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  glzw_dp #(
    .DICT_ENTRIES  (DICT_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
